FILE: src/abkf_pkg.sv
// ----------------------------------------------------------------------------
// abkf_pkg: shared definitions for the angle and gyro bias Kalman filter
// Operand and operation codes, reset values, saturation and rounding helpers
// and the micro-program that sequences one filter step.
// ----------------------------------------------------------------------------
package abkf_pkg;

    localparam int DW   = 32;
    localparam int FRAC = 24;
    localparam int CFG_IW = 3;

    localparam logic [30:0] APN_RST = 31'd16777;
    localparam logic [30:0] BPN_RST = 31'd50332;
    localparam logic [30:0] RN_RST  = 31'd8388608;
    localparam logic [30:0] DT_RST  = 31'd83886;
    localparam logic signed [31:0] C_RST   = 32'sd16777216;
    localparam logic signed [31:0] Q_ONE   = 32'sd16777216;
    localparam logic signed [31:0] S32_MAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh80000000;
    localparam logic signed [39:0] S32_MAX40 = 40'sd2147483647;
    localparam logic signed [39:0] S32_MIN40 = -40'sd2147483648;
    localparam logic signed [63:0] RND_HALF  = 64'sd8388608;

    localparam int PROG_LEN = 22;
    localparam logic [4:0] PC_LAST = 5'(PROG_LEN - 1);

    typedef enum logic [2:0] {
        CFG_APN = 3'd0,
        CFG_BPN = 3'd1,
        CFG_RN  = 3'd2,
        CFG_DT  = 3'd3,
        CFG_C   = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_MUL = 2'd1,
        OP_DIV = 2'd2
    } t_op;

    typedef enum logic [4:0] {
        SEL_ZERO  = 5'd0,
        SEL_ANGLE = 5'd1,
        SEL_BIAS  = 5'd2,
        SEL_AA    = 5'd3,
        SEL_AB    = 5'd4,
        SEL_BA    = 5'd5,
        SEL_BB    = 5'd6,
        SEL_RATE  = 5'd7,
        SEL_D     = 5'd8,
        SEL_ERR   = 5'd9,
        SEL_PC0   = 5'd10,
        SEL_PC1   = 5'd11,
        SEL_E     = 5'd12,
        SEL_K0    = 5'd13,
        SEL_K1    = 5'd14,
        SEL_T1    = 5'd15,
        SEL_GYRO  = 5'd16,
        SEL_ACCEL = 5'd17,
        SEL_APN   = 5'd18,
        SEL_BPN   = 5'd19,
        SEL_RN    = 5'd20,
        SEL_DT    = 5'd21,
        SEL_C     = 5'd22
    } t_sel;

    // A multiply step writes dst = a -/+ round(m0 * m1).
    // An add step writes dst = a -/+ b -/+ c, saturated once.
    // A divide step writes dst = m0 / m1.
    typedef struct packed {
        t_op  op;
        t_sel a;
        t_sel b;
        t_sel c;
        logic b_neg;
        logic c_neg;
        t_sel m0;
        t_sel m1;
        t_sel dst;
    } t_uop;

    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        if (v > S32_MAX40) begin
            return S32_MAX;
        end else if (v < S32_MIN40) begin
            return S32_MIN;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] qround(input logic signed [63:0] p);
        logic signed [63:0] r;
        r = p + RND_HALF;
        return sat32(signed'(r[63:24]));
    endfunction

    function automatic t_uop mk(input t_op op, input t_sel a, input t_sel b, input t_sel c,
                                input logic b_neg, input logic c_neg, input t_sel m0,
                                input t_sel m1, input t_sel dst);
        t_uop u;
        u.op    = op;
        u.a     = a;
        u.b     = b;
        u.c     = c;
        u.b_neg = b_neg;
        u.c_neg = c_neg;
        u.m0    = m0;
        u.m1    = m1;
        u.dst   = dst;
        return u;
    endfunction

    function automatic t_uop f_prog(input logic [4:0] pc);
        t_uop u;
        case (pc)
            5'd0:  u = mk(OP_ADD, SEL_GYRO, SEL_BIAS, SEL_ZERO, 1'b1, 1'b0,
                          SEL_ZERO, SEL_ZERO, SEL_RATE);
            5'd1:  u = mk(OP_MUL, SEL_ANGLE, SEL_ZERO, SEL_ZERO, 1'b0, 1'b0,
                          SEL_RATE, SEL_DT, SEL_ANGLE);
            5'd2:  u = mk(OP_ADD, SEL_APN, SEL_AB, SEL_BA, 1'b1, 1'b1,
                          SEL_ZERO, SEL_ZERO, SEL_D);
            5'd3:  u = mk(OP_MUL, SEL_AA, SEL_ZERO, SEL_ZERO, 1'b0, 1'b0,
                          SEL_D, SEL_DT, SEL_AA);
            5'd4:  u = mk(OP_ADD, SEL_ZERO, SEL_BB, SEL_ZERO, 1'b1, 1'b0,
                          SEL_ZERO, SEL_ZERO, SEL_D);
            5'd5:  u = mk(OP_MUL, SEL_AB, SEL_ZERO, SEL_ZERO, 1'b0, 1'b0,
                          SEL_D, SEL_DT, SEL_AB);
            5'd6:  u = mk(OP_MUL, SEL_BA, SEL_ZERO, SEL_ZERO, 1'b0, 1'b0,
                          SEL_D, SEL_DT, SEL_BA);
            5'd7:  u = mk(OP_MUL, SEL_BB, SEL_ZERO, SEL_ZERO, 1'b0, 1'b0,
                          SEL_BPN, SEL_DT, SEL_BB);
            5'd8:  u = mk(OP_ADD, SEL_ACCEL, SEL_ANGLE, SEL_ZERO, 1'b1, 1'b0,
                          SEL_ZERO, SEL_ZERO, SEL_ERR);
            5'd9:  u = mk(OP_MUL, SEL_ZERO, SEL_ZERO, SEL_ZERO, 1'b0, 1'b0,
                          SEL_C, SEL_AA, SEL_PC0);
            5'd10: u = mk(OP_MUL, SEL_ZERO, SEL_ZERO, SEL_ZERO, 1'b0, 1'b0,
                          SEL_C, SEL_BA, SEL_PC1);
            5'd11: u = mk(OP_MUL, SEL_RN, SEL_ZERO, SEL_ZERO, 1'b0, 1'b0,
                          SEL_C, SEL_PC0, SEL_E);
            5'd12: u = mk(OP_DIV, SEL_ZERO, SEL_ZERO, SEL_ZERO, 1'b0, 1'b0,
                          SEL_PC0, SEL_E, SEL_K0);
            5'd13: u = mk(OP_DIV, SEL_ZERO, SEL_ZERO, SEL_ZERO, 1'b0, 1'b0,
                          SEL_PC1, SEL_E, SEL_K1);
            5'd14: u = mk(OP_MUL, SEL_ZERO, SEL_ZERO, SEL_ZERO, 1'b0, 1'b0,
                          SEL_C, SEL_AB, SEL_T1);
            5'd15: u = mk(OP_MUL, SEL_AA, SEL_ZERO, SEL_ZERO, 1'b1, 1'b0,
                          SEL_K0, SEL_PC0, SEL_AA);
            5'd16: u = mk(OP_MUL, SEL_AB, SEL_ZERO, SEL_ZERO, 1'b1, 1'b0,
                          SEL_K0, SEL_T1, SEL_AB);
            5'd17: u = mk(OP_MUL, SEL_BA, SEL_ZERO, SEL_ZERO, 1'b1, 1'b0,
                          SEL_K1, SEL_PC0, SEL_BA);
            5'd18: u = mk(OP_MUL, SEL_BB, SEL_ZERO, SEL_ZERO, 1'b1, 1'b0,
                          SEL_K1, SEL_T1, SEL_BB);
            5'd19: u = mk(OP_MUL, SEL_ANGLE, SEL_ZERO, SEL_ZERO, 1'b0, 1'b0,
                          SEL_K0, SEL_ERR, SEL_ANGLE);
            5'd20: u = mk(OP_MUL, SEL_BIAS, SEL_ZERO, SEL_ZERO, 1'b0, 1'b0,
                          SEL_K1, SEL_ERR, SEL_BIAS);
            5'd21: u = mk(OP_ADD, SEL_GYRO, SEL_BIAS, SEL_ZERO, 1'b1, 1'b0,
                          SEL_ZERO, SEL_ZERO, SEL_RATE);
            default: u = mk(OP_ADD, SEL_ZERO, SEL_ZERO, SEL_ZERO, 1'b0, 1'b0,
                            SEL_ZERO, SEL_ZERO, SEL_ZERO);
        endcase
        return u;
    endfunction

endpackage

FILE: src/angle_bias_kalman_filter.sv
// Both gain divisions end early on a zero or saturating divisor, which shortens
// the step. A new word is taken only once the previous step has loaded its
// result word; the serial divider, one quotient bit a cycle for each of the two
// gains, takes most of the time of a step.
// Reset is synchronous and active low; it restores the registers and the
// filter state to their defaults and empties the output register.
// ----------------------------------------------------------------------------
// angle_bias_kalman_filter: two-state angle and gyro bias Kalman filter
// A micro-sequencer runs one predict and update step per sample through a
// shared multiplier, a saturating adder and a radix-2 divider.
// ----------------------------------------------------------------------------
module angle_bias_kalman_filter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // [31:0] accel_angle, [63:32] gyro_rate
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,  // [31:0] angle_estimate, [63:32] rate_estimate
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [abkf_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_EXEC = 5'b00010,
        ST_MULW = 5'b00100,
        ST_DIVI = 5'b01000,
        ST_DIVF = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic [4:0] r_pc, n_pc;

    logic [30:0] r_apn, r_bpn, r_rn, r_dt;
    logic signed [31:0] r_c;

    logic signed [31:0] r_angle, r_bias, r_aa, r_ab, r_ba, r_bb;
    logic signed [31:0] r_rate, r_d, r_err, r_pc0, r_pc1, r_e, r_k0, r_k1, r_t1;
    logic signed [31:0] r_gyro, r_accel;

    logic signed [63:0] r_prod;

    logic        r_dneg, r_dzero, r_dovf;
    logic [31:0] r_dmag, r_rem, r_dvd, r_quo;
    logic [4:0]  r_cnt;

    logic               r_mvalid;
    logic signed [31:0] r_mangle, r_mrate;

    abkf_pkg::t_uop     w_uop;
    logic signed [31:0] w_a, w_b, w_c, w_m0, w_m1, w_q, w_y;
    logic signed [34:0] w_ax, w_yx, w_cx, w_sum;
    logic signed [31:0] w_alu;
    logic signed [63:0] w_prod;
    logic [31:0]        w_nmag, w_dmag;
    logic               w_ovf, w_dshort;
    logic [33:0]        w_trial;
    logic signed [32:0] w_qs;
    logic signed [31:0] w_divq;
    logic               w_wr_en, w_out_load, w_accept;
    abkf_pkg::t_sel     w_wr_sel;
    logic signed [31:0] w_wr_data;

    function automatic logic signed [31:0] rd(input abkf_pkg::t_sel s);
        logic signed [31:0] v;
        case (s)
            abkf_pkg::SEL_ZERO:  v = '0;
            abkf_pkg::SEL_ANGLE: v = r_angle;
            abkf_pkg::SEL_BIAS:  v = r_bias;
            abkf_pkg::SEL_AA:    v = r_aa;
            abkf_pkg::SEL_AB:    v = r_ab;
            abkf_pkg::SEL_BA:    v = r_ba;
            abkf_pkg::SEL_BB:    v = r_bb;
            abkf_pkg::SEL_RATE:  v = r_rate;
            abkf_pkg::SEL_D:     v = r_d;
            abkf_pkg::SEL_ERR:   v = r_err;
            abkf_pkg::SEL_PC0:   v = r_pc0;
            abkf_pkg::SEL_PC1:   v = r_pc1;
            abkf_pkg::SEL_E:     v = r_e;
            abkf_pkg::SEL_K0:    v = r_k0;
            abkf_pkg::SEL_K1:    v = r_k1;
            abkf_pkg::SEL_T1:    v = r_t1;
            abkf_pkg::SEL_GYRO:  v = r_gyro;
            abkf_pkg::SEL_ACCEL: v = r_accel;
            abkf_pkg::SEL_APN:   v = signed'({1'b0, r_apn});
            abkf_pkg::SEL_BPN:   v = signed'({1'b0, r_bpn});
            abkf_pkg::SEL_RN:    v = signed'({1'b0, r_rn});
            abkf_pkg::SEL_DT:    v = signed'({1'b0, r_dt});
            abkf_pkg::SEL_C:     v = r_c;
            default:             v = '0;
        endcase
        return v;
    endfunction

    assign w_uop = abkf_pkg::f_prog(r_pc);

    always_comb begin
        w_a  = rd(w_uop.a);
        w_b  = rd(w_uop.b);
        w_c  = rd(w_uop.c);
        w_m0 = rd(w_uop.m0);
        w_m1 = rd(w_uop.m1);
    end

    assign w_prod = w_m0 * w_m1;
    assign w_q    = abkf_pkg::qround(r_prod);
    assign w_y    = (w_uop.op == abkf_pkg::OP_MUL) ? w_q : w_b;

    assign w_ax  = signed'({{3{w_a[31]}}, w_a});
    assign w_yx  = signed'({{3{w_y[31]}}, w_y});
    assign w_cx  = signed'({{3{w_c[31]}}, w_c});
    assign w_sum = w_ax + (w_uop.b_neg ? -w_yx : w_yx) + (w_uop.c_neg ? -w_cx : w_cx);
    assign w_alu = abkf_pkg::sat32(signed'({{5{w_sum[34]}}, w_sum}));

    // Divider set-up: a quotient of 2^32 or more is caught by one compare, so
    // only the low 32 quotient bits need iterating.
    assign w_nmag   = w_m0[31] ? 32'(-w_m0) : 32'(w_m0);
    assign w_dmag   = w_m1[31] ? 32'(-w_m1) : 32'(w_m1);
    assign w_ovf    = {8'd0, w_nmag} >= {w_dmag, 8'd0};
    assign w_dshort = (w_m1 == '0) || w_ovf;
    assign w_trial  = {1'b0, r_rem, r_dvd[31]} - {2'b00, r_dmag};
    assign w_qs     = r_dneg ? -signed'({1'b0, r_quo}) : signed'({1'b0, r_quo});

    always_comb begin
        if (r_dzero) begin
            w_divq = '0;
        end else if (r_dovf) begin
            w_divq = r_dneg ? abkf_pkg::S32_MIN : abkf_pkg::S32_MAX;
        end else begin
            w_divq = abkf_pkg::sat32(signed'({{7{w_qs[32]}}, w_qs}));
        end
    end

    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = {r_mrate, r_mangle};

    always_comb begin
        n_state    = r_state;
        n_pc       = r_pc;
        w_wr_en    = 1'b0;
        w_wr_sel   = w_uop.dst;
        w_wr_data  = w_alu;
        w_out_load = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (w_uop.op)
                    abkf_pkg::OP_ADD: begin
                        if (r_pc == abkf_pkg::PC_LAST) begin
                            if (!r_mvalid || m_axis_tready) begin
                                w_wr_en    = 1'b1;
                                w_out_load = 1'b1;
                                n_pc       = '0;
                                n_state    = ST_IDLE;
                            end
                        end else begin
                            w_wr_en = 1'b1;
                            n_pc    = r_pc + 5'd1;
                        end
                    end
                    abkf_pkg::OP_MUL: begin
                        n_state = ST_MULW;
                    end
                    abkf_pkg::OP_DIV: begin
                        n_state = w_dshort ? ST_DIVF : ST_DIVI;
                    end
                    default: begin
                        n_state = ST_IDLE;
                    end
                endcase
            end
            ST_MULW: begin
                w_wr_en = 1'b1;
                n_pc    = r_pc + 5'd1;
                n_state = ST_EXEC;
            end
            ST_DIVI: begin
                if (r_cnt == '0) begin
                    n_state = ST_DIVF;
                end
            end
            ST_DIVF: begin
                w_wr_en   = 1'b1;
                w_wr_data = w_divq;
                n_pc      = r_pc + 5'd1;
                n_state   = ST_EXEC;
            end
            default: begin
                n_state = ST_IDLE;
                n_pc    = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_pc     <= '0;
            r_mvalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            if (w_out_load) begin
                r_mvalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_mvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_apn <= abkf_pkg::APN_RST;
            r_bpn <= abkf_pkg::BPN_RST;
            r_rn  <= abkf_pkg::RN_RST;
            r_dt  <= abkf_pkg::DT_RST;
            r_c   <= abkf_pkg::C_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (abkf_pkg::t_cfg_idx'(i_cfg_index))
                abkf_pkg::CFG_APN: r_apn <= i_cfg_data[30:0];
                abkf_pkg::CFG_BPN: r_bpn <= i_cfg_data[30:0];
                abkf_pkg::CFG_RN:  r_rn  <= i_cfg_data[30:0];
                abkf_pkg::CFG_DT:  r_dt  <= i_cfg_data[30:0];
                abkf_pkg::CFG_C:   r_c   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle <= '0;
            r_bias  <= '0;
            r_aa    <= abkf_pkg::Q_ONE;
            r_ab    <= '0;
            r_ba    <= '0;
            r_bb    <= abkf_pkg::Q_ONE;
        end else if (w_wr_en) begin
            case (w_wr_sel)
                abkf_pkg::SEL_ANGLE: r_angle <= w_wr_data;
                abkf_pkg::SEL_BIAS:  r_bias  <= w_wr_data;
                abkf_pkg::SEL_AA:    r_aa    <= w_wr_data;
                abkf_pkg::SEL_AB:    r_ab    <= w_wr_data;
                abkf_pkg::SEL_BA:    r_ba    <= w_wr_data;
                abkf_pkg::SEL_BB:    r_bb    <= w_wr_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            case (w_wr_sel)
                abkf_pkg::SEL_RATE: r_rate <= w_wr_data;
                abkf_pkg::SEL_D:    r_d    <= w_wr_data;
                abkf_pkg::SEL_ERR:  r_err  <= w_wr_data;
                abkf_pkg::SEL_PC0:  r_pc0  <= w_wr_data;
                abkf_pkg::SEL_PC1:  r_pc1  <= w_wr_data;
                abkf_pkg::SEL_E:    r_e    <= w_wr_data;
                abkf_pkg::SEL_K0:   r_k0   <= w_wr_data;
                abkf_pkg::SEL_K1:   r_k1   <= w_wr_data;
                abkf_pkg::SEL_T1:   r_t1   <= w_wr_data;
                default: begin
                end
            endcase
        end
        if (w_accept) begin
            r_accel <= signed'(s_axis_tdata[31:0]);
            r_gyro  <= signed'(s_axis_tdata[63:32]);
        end
        if (w_out_load) begin
            r_mangle <= r_angle;
            r_mrate  <= w_alu;
        end
        if (r_state == ST_EXEC && w_uop.op == abkf_pkg::OP_MUL) begin
            r_prod <= w_prod;
        end
        if (r_state == ST_EXEC && w_uop.op == abkf_pkg::OP_DIV) begin
            r_dneg  <= w_m0[31] ^ w_m1[31];
            r_dzero <= (w_m1 == '0);
            r_dovf  <= w_ovf;
            r_dmag  <= w_dmag;
            r_rem   <= {8'd0, w_nmag[31:8]};
            r_dvd   <= {w_nmag[7:0], 24'd0};
            r_cnt   <= '1;
        end else if (r_state == ST_DIVI) begin
            r_rem <= w_trial[33] ? {r_rem[30:0], r_dvd[31]} : w_trial[31:0];
            r_quo <= {r_quo[30:0], ~w_trial[33]};
            r_dvd <= {r_dvd[30:0], 1'b0};
            r_cnt <= r_cnt - 5'd1;
        end
    end

    a_idle_pc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_pc == '0))
        else $error("Sequencer idle with a step pending.");

    a_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIVI) |-> (r_rem < r_dmag))
        else $error("Divider remainder not below the divisor.");

    a_div_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIVI && r_cnt == '0) |=> (r_state == ST_DIVF))
        else $error("Divider overran its bit count.");

    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_mvalid) |-> ($past(r_state) == ST_EXEC && r_state == ST_IDLE))
        else $error("Result word raised outside the final step.");

endmodule

FILE: tb/sv/angle_bias_kalman_filter_checker.sv
// ----------------------------------------------------------------------------
// angle_bias_kalman_filter_checker: estimate checker for the Kalman filter
// Watches the configuration, sample and estimate channels. It keeps its own
// copy of the filter registers and state, and predicts the angle and rate
// estimates for every accepted sample word. Each accepted estimate word is
// compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module angle_bias_kalman_filter_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic [63:0]                 i_in_data,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic [63:0]                 i_out_data,
    input  logic                        i_cfg_valid,
    input  logic                        i_cfg_ready,
    input  logic [abkf_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [31:0]                 i_cfg_data,
    output int                          o_fail_count,
    output int                          o_pending
);

    typedef struct {
        logic signed [31:0] angle;
        logic signed [31:0] rate;
    } t_estimate;

    logic [30:0]        angle_noise;
    logic [30:0]        bias_noise;
    logic [30:0]        measure_noise;
    logic [30:0]        sample_period;
    logic signed [31:0] observe_gain;

    logic signed [31:0] angle_est;
    logic signed [31:0] bias_est;
    logic signed [31:0] cov_aa;
    logic signed [31:0] cov_ab;
    logic signed [31:0] cov_ba;
    logic signed [31:0] cov_bb;

    t_estimate estimate_q[$];
    int        mismatches = 0;

    function automatic logic signed [31:0] sat(input longint v);
        if (v > longint'(abkf_pkg::S32_MAX)) begin
            return abkf_pkg::S32_MAX;
        end else if (v < longint'(abkf_pkg::S32_MIN)) begin
            return abkf_pkg::S32_MIN;
        end
        return 32'(v);
    endfunction

    // Rounds to nearest with ties towards plus infinity.
    function automatic logic signed [31:0] fx_mul(input longint a, input longint b);
        longint p;
        p = a * b + (64'sd1 <<< (abkf_pkg::FRAC - 1));
        return sat(p >>> abkf_pkg::FRAC);
    endfunction

    function automatic logic signed [31:0] fx_div(input longint num, input longint den);
        if (den == 0) begin
            return '0;
        end
        return sat((num <<< abkf_pkg::FRAC) / den);
    endfunction

    function automatic t_estimate filter_step(input logic signed [31:0] accel,
                                              input logic signed [31:0] gyro);
        longint    dt, gain, d0, d1, err, pc0, pc1, e, k0, k1, t1;
        t_estimate est;
        dt   = longint'(sample_period);
        gain = longint'(observe_gain);

        angle_est = sat(longint'(angle_est)
                        + fx_mul(sat(longint'(gyro) - longint'(bias_est)), dt));
        d0 = sat(longint'(angle_noise) - longint'(cov_ab) - longint'(cov_ba));
        d1 = sat(-longint'(cov_bb));
        cov_aa = sat(longint'(cov_aa) + fx_mul(d0, dt));
        cov_ab = sat(longint'(cov_ab) + fx_mul(d1, dt));
        cov_ba = sat(longint'(cov_ba) + fx_mul(d1, dt));
        cov_bb = sat(longint'(cov_bb) + fx_mul(longint'(bias_noise), dt));

        // The innovation leaves the observation gain off the angle.
        err = sat(longint'(accel) - longint'(angle_est));
        pc0 = fx_mul(gain, cov_aa);
        pc1 = fx_mul(gain, cov_ba);
        e   = sat(longint'(measure_noise) + fx_mul(gain, pc0));
        k0  = fx_div(pc0, e);
        k1  = fx_div(pc1, e);
        t1  = fx_mul(gain, cov_ab);
        cov_aa = sat(longint'(cov_aa) - fx_mul(k0, pc0));
        cov_ab = sat(longint'(cov_ab) - fx_mul(k0, t1));
        cov_ba = sat(longint'(cov_ba) - fx_mul(k1, pc0));
        cov_bb = sat(longint'(cov_bb) - fx_mul(k1, t1));
        angle_est = sat(longint'(angle_est) + fx_mul(k0, err));
        bias_est  = sat(longint'(bias_est) + fx_mul(k1, err));

        est.angle = angle_est;
        est.rate  = sat(longint'(gyro) - longint'(bias_est));
        return est;
    endfunction

    always @(posedge i_clk) begin
        t_estimate got;
        t_estimate want;
        if (!i_rst_n) begin
            angle_noise   = abkf_pkg::APN_RST;
            bias_noise    = abkf_pkg::BPN_RST;
            measure_noise = abkf_pkg::RN_RST;
            sample_period = abkf_pkg::DT_RST;
            observe_gain  = abkf_pkg::C_RST;
            angle_est     = '0;
            bias_est      = '0;
            cov_aa        = abkf_pkg::Q_ONE;
            cov_ab        = '0;
            cov_ba        = '0;
            cov_bb        = abkf_pkg::Q_ONE;
            estimate_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (abkf_pkg::t_cfg_idx'(i_cfg_index))
                    abkf_pkg::CFG_APN: angle_noise   = i_cfg_data[30:0];
                    abkf_pkg::CFG_BPN: bias_noise    = i_cfg_data[30:0];
                    abkf_pkg::CFG_RN:  measure_noise = i_cfg_data[30:0];
                    abkf_pkg::CFG_DT:  sample_period = i_cfg_data[30:0];
                    abkf_pkg::CFG_C:   observe_gain  = signed'(i_cfg_data);
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                estimate_q.push_back(filter_step(signed'(i_in_data[31:0]),
                                                 signed'(i_in_data[63:32])));
            end
            if (i_out_valid && i_out_ready) begin
                got.angle = signed'(i_out_data[31:0]);
                got.rate  = signed'(i_out_data[63:32]);
                if (estimate_q.size() == 0) begin
                    $error("estimate word with none pending: %s %0d, %s %0d",
                           "angle_estimate", got.angle, "rate_estimate", got.rate);
                    mismatches++;
                end else begin
                    want = estimate_q.pop_front();
                    if (got.angle !== want.angle) begin
                        $error("angle_estimate: expected %0d, got %0d", want.angle, got.angle);
                        mismatches++;
                    end
                    if (got.rate !== want.rate) begin
                        $error("rate_estimate: expected %0d, got %0d", want.rate, got.rate);
                        mismatches++;
                    end
                end
            end
        end
        o_pending    <= estimate_q.size();
        o_fail_count <= mismatches;
    end

endmodule

FILE: tb/sv/angle_bias_kalman_filter_test.sv
// ----------------------------------------------------------------------------
// angle_bias_kalman_filter_test: top level test of the angle Kalman filter
// Drives sample words in random bursts through a directed opening, directed
// register settings and a series of random ones, with the estimate side stalling on a
// pattern of its own. The checker beside the filter predicts and compares.
// ----------------------------------------------------------------------------
module angle_bias_kalman_filter_test;

    localparam int LIMIT         = 2_000_000;
    localparam int REG_COUNT     = 5;
    localparam int RAND_PHASES   = 10;
    localparam int PHASE_WORDS   = 185;
    localparam int SETTLE_CYCLES = 120;
    localparam int IDX_W         = abkf_pkg::CFG_IW;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_CHOPPY,
        RX_CHOKED
    } t_rx_mode;

    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [63:0]      s_axis_tdata  = '0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [63:0]      m_axis_tdata;
    logic             i_cfg_valid   = 1'b0;
    logic             o_cfg_ready;
    logic [IDX_W-1:0] i_cfg_index   = '0;
    logic [31:0]      i_cfg_data    = '0;

    int       fail_count;
    int       pending;
    int       cycle_count = 0;
    int       burst_left  = 0;
    int       rx_left     = 0;
    t_rx_mode rx_mode     = RX_OPEN;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    angle_bias_kalman_filter dut (.*);

    angle_bias_kalman_filter_checker estimate_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode <= t_rx_mode'($urandom_range(0, 2));
            rx_left <= $urandom_range(20, 300);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_OPEN:   m_axis_tready <= 1'b1;
            RX_CHOPPY: m_axis_tready <= 1'($urandom_range(0, 1));
            default:   m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Mostly plausible values within +/- span, with full-range and extreme ones mixed in.
    function automatic logic [31:0] rand_q824(input int unsigned span);
        int unsigned k;
        k = $urandom_range(0, 99);
        if (k < 6) begin
            case ($urandom_range(0, 4))
                0:       return abkf_pkg::S32_MAX;
                1:       return abkf_pkg::S32_MIN;
                2:       return '0;
                3:       return '1;
                default: return 32'd1;
            endcase
        end
        if (k < 22) begin
            return $urandom();
        end
        return $urandom_range(0, 2 * span) - span;
    endfunction

    function automatic logic [31:0] cfg_value(input abkf_pkg::t_cfg_idx idx);
        int unsigned r;
        logic [31:0] typical;
        r = $urandom_range(0, 9);
        case (idx)
            abkf_pkg::CFG_APN, abkf_pkg::CFG_BPN: typical = $urandom_range(0, 1 << 18);
            abkf_pkg::CFG_RN:  typical = $urandom_range(1, 1 << 26);
            abkf_pkg::CFG_DT:  typical = $urandom_range(0, 1 << 20);
            default: typical = abkf_pkg::Q_ONE + $urandom_range(0, 1 << 24) - (1 << 23);
        endcase
        if (r < 6) begin
            return typical;
        end
        if (r == 6) begin
            return (idx == abkf_pkg::CFG_C) ? abkf_pkg::S32_MIN : '0;
        end
        if (r == 7) begin
            return abkf_pkg::S32_MAX;
        end
        return $urandom();
    endfunction

    task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        while (!o_cfg_ready) begin
            @(negedge i_clk);
        end
        @(posedge i_clk);
    endtask

    // Every register is written, then an index beyond the list that must be ignored.
    task automatic set_registers(input logic [31:0] apn, input logic [31:0] bpn,
                                 input logic [31:0] rn, input logic [31:0] dt,
                                 input logic [31:0] gain);
        cfg_write(abkf_pkg::CFG_APN, apn);
        cfg_write(abkf_pkg::CFG_BPN, bpn);
        cfg_write(abkf_pkg::CFG_RN, rn);
        cfg_write(abkf_pkg::CFG_DT, dt);
        cfg_write(abkf_pkg::CFG_C, gain);
        cfg_write(IDX_W'($urandom_range(REG_COUNT, (1 << IDX_W) - 1)), $urandom());
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_sample(input logic [31:0] accel, input logic [31:0] gyro);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 130);
            burst_left = $urandom_range(1, 16);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {gyro, accel};
        @(negedge i_clk);
        while (!s_axis_tready) begin
            @(negedge i_clk);
        end
        @(posedge i_clk);
    endtask

    task automatic close_phase();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_sample('0, '0);
        send_sample(abkf_pkg::S32_MAX, '0);
        send_sample(abkf_pkg::S32_MIN, '0);
        send_sample('0, abkf_pkg::S32_MAX);
        send_sample('0, abkf_pkg::S32_MIN);
        send_sample(abkf_pkg::S32_MAX, abkf_pkg::S32_MAX);
        send_sample(abkf_pkg::S32_MIN, abkf_pkg::S32_MIN);
        send_sample(abkf_pkg::S32_MIN, abkf_pkg::S32_MAX);
        send_sample(abkf_pkg::S32_MAX, abkf_pkg::S32_MIN);
        send_sample(abkf_pkg::Q_ONE, -abkf_pkg::Q_ONE);
        send_sample('1, '1);
        send_sample(32'd1, 32'd1);
        close_phase();

        // Top bits set on the unsigned registers must be dropped.
        set_registers('1, '1, '1, '1, abkf_pkg::S32_MAX);
        send_sample(abkf_pkg::Q_ONE, abkf_pkg::Q_ONE);
        send_sample(abkf_pkg::S32_MIN, abkf_pkg::S32_MAX);
        send_sample('0, '0);
        close_phase();

        // A zero innovation variance leaves both gains at zero.
        set_registers('0, '0, '0, '0, '0);
        send_sample(abkf_pkg::Q_ONE, abkf_pkg::Q_ONE);
        send_sample(abkf_pkg::S32_MAX, abkf_pkg::S32_MIN);
        send_sample('0, '0);
        close_phase();

        set_registers(abkf_pkg::APN_RST, abkf_pkg::BPN_RST, 32'd1, abkf_pkg::Q_ONE,
                      abkf_pkg::S32_MIN);
        send_sample(-abkf_pkg::Q_ONE, abkf_pkg::Q_ONE);
        send_sample(abkf_pkg::S32_MAX, '0);
        send_sample('0, -abkf_pkg::Q_ONE);
        close_phase();

        for (int p = 0; p < RAND_PHASES; p++) begin
            set_registers(cfg_value(abkf_pkg::CFG_APN), cfg_value(abkf_pkg::CFG_BPN),
                          cfg_value(abkf_pkg::CFG_RN), cfg_value(abkf_pkg::CFG_DT),
                          cfg_value(abkf_pkg::CFG_C));
            for (int n = 0; n < PHASE_WORDS; n++) begin
                send_sample(rand_q824(1 << 26), rand_q824(1 << 25));
            end
            close_phase();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: filelist.f
src/abkf_pkg.sv
src/angle_bias_kalman_filter.sv
tb/sv/angle_bias_kalman_filter_checker.sv
tb/sv/angle_bias_kalman_filter_test.sv
